>>> rtl/ssd_pkg.sv
package ssd_pkg;

  localparam int unsigned ValueWidth    = 11;
  localparam int unsigned MaskWidth     = 3;
  localparam int unsigned DigitWidth    = 4;
  localparam int unsigned RestWidth     = 7;
  localparam int unsigned PosWidth      = 2;
  localparam int unsigned SegWidth      = 8;
  localparam int unsigned IntervalWidth = 8;

  localparam logic [DigitWidth-1:0] DashCode     = 4'd10;
  localparam logic [SegWidth-1:0]   BlankPattern = 8'hFD;
  localparam logic [SegWidth-1:0]   PointMaskOff = 8'hFD;
  localparam logic [SegWidth-1:0]   PointBit     = 8'h02;

  localparam logic [PosWidth-1:0] PosUnits    = 2'd0;
  localparam logic [PosWidth-1:0] PosTens     = 2'd1;
  localparam logic [PosWidth-1:0] PosHundreds = 2'd2;
  localparam logic [PosWidth-1:0] PosUnused   = 2'd3;

  // Reciprocal constants: x / 100 == (x * 1311) >> 17 for x below 2048,
  // and x / 10 == (x * 205) >> 11 for x below 100.
  localparam logic [10:0] Recip100      = 11'd1311;
  localparam int unsigned Recip100Shift = 17;
  localparam logic [7:0]  Recip10       = 8'd205;
  localparam int unsigned Recip10Shift  = 11;

  function automatic logic [SegWidth-1:0] seg_lookup(input logic [DigitWidth-1:0] digit);
    logic [SegWidth-1:0] pat;
    unique case (digit)
      4'd0:    pat = 8'h0A;
      4'd1:    pat = 8'h7B;
      4'd2:    pat = 8'h26;
      4'd3:    pat = 8'h62;
      4'd4:    pat = 8'h53;
      4'd5:    pat = 8'hC2;
      4'd6:    pat = 8'h82;
      4'd7:    pat = 8'h6B;
      4'd8:    pat = 8'h02;
      4'd9:    pat = 8'h42;
      default: pat = 8'hF7;
    endcase
    return pat;
  endfunction

endpackage

>>> rtl/seven_segment_scan_driver_top.sv
// Three-digit multiplexed seven-segment scan driver. Each input item is one refresh tick and
// yields exactly one output item: the digit index (scanning units, tens, hundreds) and the
// active-low segment byte for that digit, with bit 1 as the decimal point. Values of 1000 and
// above show a dash in the hundreds place. While blink is enabled, a triangle counter of
// blink_interval + 1 ticks per half alternates between shown and blanked digits. The block
// takes one item per clock cycle while the output is not stalled: an input register splits
// the value into hundreds and remainder, and the output register holds the looked-up
// segment byte. A stalled output is absorbed by the input register, so one more item is
// taken before in_tready drops.
module seven_segment_scan_driver_top import ssd_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_wr_en,
  input  logic [7:0]  cfg_wr_data,   // blink_interval
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [15:0] in_tdata,      // display_value[10:0], point_mask[13:11], blink_enable[14]
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [15:0] out_tdata      // digit_index[1:0], segments_n[9:2]
);

  logic [IntervalWidth-1:0] blink_interval_r;
  logic [PosWidth-1:0]      scan_pos_r, scan_pos_nxt;
  logic [IntervalWidth-1:0] blink_count_r, blink_count_nxt;
  logic                     blink_falling_r, blink_falling_nxt;

  logic                     s1_valid_r;
  logic [DigitWidth-1:0]    s1_hund_r;
  logic [RestWidth-1:0]     s1_rest_r;
  logic [MaskWidth-1:0]     s1_mask_r;
  logic                     s1_blink_r;

  logic                     out_valid_r;
  logic [PosWidth-1:0]      out_pos_r;
  logic [SegWidth-1:0]      out_seg_r;

  logic                     s2_load;
  logic                     s1_load;

  logic [ValueWidth-1:0]    in_value;
  logic [21:0]              hund_prod;
  logic [4:0]               hund_raw;
  logic [11:0]              hund_times100;
  logic [RestWidth-1:0]     rest;
  logic [DigitWidth-1:0]    hund_sat;

  logic [14:0]              tens_prod;
  logic [DigitWidth-1:0]    tens;
  logic [RestWidth-1:0]     tens_times10;
  logic [DigitWidth-1:0]    units;
  logic [DigitWidth-1:0]    digit_sel;
  logic [PosWidth-1:0]      pos_eff;
  logic                     blank;
  logic [SegWidth-1:0]      seg_base;
  logic [SegWidth-1:0]      seg_nxt;

  assign s2_load   = s1_valid_r && (!out_valid_r || out_tready);
  assign in_tready = !s1_valid_r || s2_load;
  assign s1_load   = in_tvalid && in_tready;

  // Input stage: split value into hundreds and remainder.
  assign in_value      = in_tdata[ValueWidth-1:0];
  assign hund_prod     = 22'(in_value) * 22'(Recip100);
  assign hund_raw      = hund_prod[21:Recip100Shift];
  assign hund_times100 = 12'(hund_raw) * 12'd100;
  assign rest          = RestWidth'(12'(in_value) - hund_times100);
  assign hund_sat      = (hund_raw > 5'(DashCode)) ? DashCode : hund_raw[DigitWidth-1:0];

  // Output stage: tens and units, blink step, segment lookup.
  assign tens_prod    = 15'(s1_rest_r) * 15'(Recip10);
  assign tens         = tens_prod[14:Recip10Shift];
  assign tens_times10 = RestWidth'(tens) * 7'd10;
  assign units        = DigitWidth'(s1_rest_r - tens_times10);

  assign pos_eff = (scan_pos_r == PosUnused) ? PosUnits : scan_pos_r;

  always_comb begin
    blank             = 1'b0;
    blink_count_nxt   = blink_count_r;
    blink_falling_nxt = blink_falling_r;
    if (s1_blink_r) begin
      if (!blink_falling_r) begin
        if (blink_count_r < blink_interval_r) begin
          blink_count_nxt = blink_count_r + 8'd1;
        end else begin
          blink_falling_nxt = 1'b1;
          blank             = 1'b1;
        end
      end else begin
        if (blink_count_r != '0) begin
          blink_count_nxt = blink_count_r - 8'd1;
          blank           = 1'b1;
        end else begin
          blink_falling_nxt = 1'b0;
        end
      end
    end
  end

  always_comb begin
    unique case (pos_eff)
      PosTens:     digit_sel = tens;
      PosHundreds: digit_sel = s1_hund_r;
      default:     digit_sel = units;
    endcase
  end

  assign seg_base     = blank ? BlankPattern : seg_lookup(digit_sel);
  assign seg_nxt      = s1_mask_r[pos_eff] ? (seg_base & PointMaskOff)
                                           : ((seg_base & PointMaskOff) | PointBit);
  assign scan_pos_nxt = (pos_eff == PosHundreds) ? PosUnits : pos_eff + 2'd1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      blink_interval_r <= 8'd70;
      scan_pos_r       <= PosUnits;
      blink_count_r    <= '0;
      blink_falling_r  <= 1'b0;
      s1_valid_r       <= 1'b0;
      out_valid_r      <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        blink_interval_r <= cfg_wr_data;
      end
      if (s1_load) begin
        s1_valid_r <= 1'b1;
      end else if (s2_load) begin
        s1_valid_r <= 1'b0;
      end
      if (s2_load) begin
        out_valid_r     <= 1'b1;
        scan_pos_r      <= scan_pos_nxt;
        blink_count_r   <= blink_count_nxt;
        blink_falling_r <= blink_falling_nxt;
      end else if (out_tready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1_hund_r  <= hund_sat;
      s1_rest_r  <= rest;
      s1_mask_r  <= in_tdata[13:11];
      s1_blink_r <= in_tdata[14];
    end
    if (s2_load) begin
      out_pos_r <= pos_eff;
      out_seg_r <= seg_nxt;
    end
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = {6'b0, out_seg_r, out_pos_r};

`ifndef SYNTHESIS
  a_scan_pos_legal: assert property (@(posedge clk) disable iff (!rst_n)
    scan_pos_r != PosUnused) else $error("scan position reached unused code");

  a_digit_legal: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid_r |-> out_pos_r != PosUnused) else $error("output digit index out of range");

  a_skid_holds: assert property (@(posedge clk) disable iff (!rst_n)
    s1_valid_r && !s2_load |=> s1_valid_r) else $error("buffered item dropped");

  a_blink_hold: assert property (@(posedge clk) disable iff (!rst_n)
    s2_load && !s1_blink_r |=> $stable(blink_count_r) && $stable(blink_falling_r))
    else $error("blink counter moved while blink disabled");
`endif

endmodule

>>> tb/sv/tb_top.sv
module tb_top;
  import ssd_pkg::*;

  localparam int unsigned StallLimit = 5000;
  localparam logic [SegWidth-1:0] DigitPatterns [11] = '{
    8'h0A, 8'h7B, 8'h26, 8'h62, 8'h53, 8'hC2, 8'h82, 8'h6B, 8'h02, 8'h42, 8'hF7
  };

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  typedef struct packed {
    logic [PosWidth-1:0] digit;
    logic [SegWidth-1:0] segments;
  } digit_drive_t;

  class digit_scoreboard;
    digit_drive_t expected_drives[$];
    logic [IntervalWidth-1:0] interval;
    logic [PosWidth-1:0] scan_pos;
    logic [IntervalWidth-1:0] blink_cnt;
    logic blink_down;
    int unsigned errors;

    function new();
      interval = 8'd70;
      scan_pos = PosUnits;
      blink_cnt = '0;
      blink_down = 1'b0;
      errors = 0;
    endfunction

    function void set_interval(logic [IntervalWidth-1:0] val);
      interval = val;
    endfunction

    function int pending();
      return expected_drives.size();
    endfunction

    function void note_tick(logic [15:0] data);
      logic [ValueWidth-1:0] value;
      logic [MaskWidth-1:0] mask;
      logic blink_on;
      logic blank;
      int unsigned hund;
      int unsigned rest;
      logic [DigitWidth-1:0] digits [3];
      logic [PosWidth-1:0] pos;
      digit_drive_t drive;
      value = data[10:0];
      mask = data[13:11];
      blink_on = data[14];
      blank = 1'b0;
      hund = value / 100;
      rest = value % 100;
      if (hund > DashCode) begin
        hund = DashCode;
      end
      digits[0] = DigitWidth'(rest % 10);
      digits[1] = DigitWidth'(rest / 10);
      digits[2] = DigitWidth'(hund);
      if (blink_on) begin
        if (!blink_down) begin
          if (blink_cnt < interval) begin
            blink_cnt = blink_cnt + 1'b1;
          end else begin
            blink_down = 1'b1;
            blank = 1'b1;
          end
        end else if (blink_cnt != 0) begin
          blink_cnt = blink_cnt - 1'b1;
          blank = 1'b1;
        end else begin
          blink_down = 1'b0;
        end
      end
      pos = (scan_pos == PosUnused) ? PosUnits : scan_pos;
      drive.digit = pos;
      drive.segments = blank ? BlankPattern : DigitPatterns[digits[pos]];
      drive.segments = drive.segments & PointMaskOff;
      if (!mask[pos]) begin
        drive.segments = drive.segments | PointBit;
      end
      scan_pos = (pos == PosHundreds) ? PosUnits : pos + 1'b1;
      expected_drives.push_back(drive);
    endfunction

    function void check_drive(logic [15:0] data);
      digit_drive_t want;
      if (expected_drives.size() == 0) begin
        $display("%0t: unexpected item, got digit %0d segments %02h", $time, data[1:0],
                 data[9:2]);
        errors++;
        return;
      end
      want = expected_drives.pop_front();
      if (data[1:0] !== want.digit) begin
        $display("%0t: digit_index expected %0d, got %0d", $time, want.digit, data[1:0]);
        errors++;
      end
      if (data[9:2] !== want.segments) begin
        $display("%0t: segments_n expected %02h, got %02h", $time, want.segments, data[9:2]);
        errors++;
      end
    endfunction
  endclass

  logic clk;
  logic rst_n;
  logic cfg_wr_en;
  logic [7:0] cfg_wr_data;
  logic in_tvalid;
  logic in_tready;
  logic [15:0] in_tdata;
  logic out_tvalid;
  logic out_tready;
  logic [15:0] out_tdata;

  digit_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_stall_pct;
  int unsigned quiet_cycles;

  seven_segment_scan_driver_top dut (
    .clk        (clk),
    .rst_n      (rst_n),
    .cfg_wr_en  (cfg_wr_en),
    .cfg_wr_data(cfg_wr_data),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata)
  );

  always begin
    clk = 1'b0;
    #6;
    clk = 1'b1;
    #6;
  end

  always @(negedge clk) begin
    out_tready <= ($urandom_range(99) >= recv_stall_pct);
  end

  always @(posedge clk) begin
    if (rst_n && in_tvalid && in_tready) begin
      sb.note_tick(in_tdata);
    end
    if (rst_n && out_tvalid && out_tready) begin
      sb.check_drive(out_tdata);
    end
    if ((in_tvalid && in_tready) || (out_tvalid && out_tready)) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
    end
    if (quiet_cycles >= StallLimit) begin
      $display("Mismatches found");
      $finish;
    end
  end

  task automatic set_idling(input idle_mode_t mode);
    send_idle_pct = (mode == IDLE_SENDER) ? 60 : (mode == IDLE_BOTH) ? 17 : 0;
    recv_stall_pct = (mode == IDLE_RECEIVER) ? 60 : (mode == IDLE_BOTH) ? 17 : 0;
  endtask

  task automatic send_tick(input logic [10:0] value, input logic [2:0] mask,
                           input logic blink);
    while ($urandom_range(99) < send_idle_pct) begin
      in_tvalid <= 1'b0;
      @(negedge clk);
    end
    in_tvalid <= 1'b1;
    in_tdata <= {1'b0, blink, mask, value};
    do @(posedge clk); while (!in_tready);
    @(negedge clk);
  endtask

  task automatic write_interval(input logic [7:0] val);
    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
    cfg_wr_en <= 1'b1;
    cfg_wr_data <= val;
    @(negedge clk);
    cfg_wr_en <= 1'b0;
    sb.set_interval(val);
  endtask

  task automatic send_random_tick(input int unsigned blink_pct);
    logic [10:0] value;
    if ($urandom_range(9) == 0) begin
      value = 11'($urandom_range(2047, 1100));
    end else begin
      value = 11'($urandom_range(1099, 0));
    end
    send_tick(value, 3'($urandom_range(7, 0)), $urandom_range(99) < blink_pct);
  endtask

  initial begin
    logic [10:0] corner_values [12];
    logic [7:0] phase_intervals [8];
    sb = new();
    quiet_cycles = 0;
    send_idle_pct = 0;
    recv_stall_pct = 0;
    rst_n = 1'b0;
    cfg_wr_en = 1'b0;
    cfg_wr_data = '0;
    in_tvalid = 1'b0;
    in_tdata = '0;
    out_tready = 1'b0;
    corner_values = '{11'd0, 11'd9, 11'd10, 11'd99, 11'd100, 11'd999,
                      11'd1000, 11'd1099, 11'd1100, 11'd2047, 11'd1234, 11'd876};
    phase_intervals = '{8'd255, 8'd3, 8'd0, 8'd1, 8'd0, 8'd200, 8'd2, 8'd0};
    phase_intervals[4] = 8'($urandom_range(255, 0));
    phase_intervals[7] = 8'($urandom_range(255, 0));
    repeat (10) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    set_idling(IDLE_NONE);
    for (int i = 0; i < 12; i++) begin
      send_tick(corner_values[i], i[2:0], 1'b0);
    end
    for (int i = 0; i < 6; i++) begin
      send_tick(11'd555, 3'b111, 1'b1);
    end
    write_interval(8'd0);
    for (int i = 0; i < 8; i++) begin
      send_tick(11'd888, i[2:0], 1'b1);
    end

    // Blink keeps counting from the directed part, so each new interval may land below the count.
    for (int p = 0; p < 9; p++) begin
      if (p > 0) begin
        write_interval(phase_intervals[p-1]);
      end
      set_idling(idle_mode_t'(p % 4));
      for (int i = 0; i < 88; i++) begin
        send_random_tick(90);
      end
    end

    in_tvalid <= 1'b0;
    while (sb.pending() != 0) @(posedge clk);
    repeat (8) @(posedge clk);
    if (sb.errors == 0 && sb.pending() == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
